FILE: sv/ccl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccl_pkg: charge connector lock controller package
// payload types, controller state, configuration set and code constants
// ----------------------------------------------------------------------------
package ccl_pkg;

  // controller modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_ONE   = 3'd1;
  localparam logic [2:0] MODE_TWO   = 3'd2;
  localparam logic [2:0] MODE_END   = 3'd3;
  localparam logic [2:0] MODE_FAULT = 3'd4;

  // error codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT  = 2'd2;

  // lock drive levels
  localparam logic [1:0] DRIVE_STOP    = 2'd0;
  localparam logic [1:0] DRIVE_ENGAGE  = 2'd1;
  localparam logic [1:0] DRIVE_RELEASE = 2'd2;

  // lock phases
  localparam logic [1:0] PHASE_OPEN      = 2'd0;
  localparam logic [1:0] PHASE_ENGAGING  = 2'd1;
  localparam logic [1:0] PHASE_LOCKED    = 2'd2;
  localparam logic [1:0] PHASE_RELEASING = 2'd3;

  // largest legal detect mask
  localparam logic [7:0] DETECT_LIMIT = 8'd31;

  // register indexes
  localparam logic [2:0] REG_LINE_DETECT   = 3'd0;
  localparam logic [2:0] REG_SEAT_ONE      = 3'd1;
  localparam logic [2:0] REG_SEAT_TWO      = 3'd2;
  localparam logic [2:0] REG_LOCK_CLOSE    = 3'd3;
  localparam logic [2:0] REG_LOCK_OPEN     = 3'd4;
  localparam logic [2:0] REG_POWER_TIMEOUT = 3'd5;

  // register reset values
  localparam logic [4:0]  LINE_DETECT_RST   = 5'd1;
  localparam logic [7:0]  SEAT_ONE_RST      = 8'd1;
  localparam logic [7:0]  SEAT_TWO_RST      = 8'd2;
  localparam logic [15:0] LOCK_CLOSE_RST    = 16'd120;
  localparam logic [15:0] LOCK_OPEN_RST     = 16'd180;
  localparam logic [15:0] POWER_TIMEOUT_RST = 16'd3000;

  typedef struct packed {
    logic [7:0]  detect_mask;
    logic [7:0]  power_mask;
    logic [31:0] now_ms;
    logic        clear_error;
  } in_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] error_code;
    logic [1:0] lock_drive;
    logic       error_led;
  } out_t;

  typedef struct packed {
    logic [4:0]  line_detect_bits;
    logic [7:0]  seat_one_bits;
    logic [7:0]  seat_two_bits;
    logic [15:0] lock_close_ms;
    logic [15:0] lock_open_ms;
    logic [15:0] power_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  current_mode;
    logic [1:0]  stored_error;
    logic [1:0]  lock_phase;
    logic [31:0] lock_stamp;
    logic        wait_running;
    logic [31:0] wait_start;
    logic [1:0]  drive_level;
  } state_t;

endpackage

FILE: sv/ccl_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccl_step: one control pass
// next controller state from the current state, configuration and one input
// ----------------------------------------------------------------------------
module ccl_step (
  input  ccl_pkg::state_t cur,
  input  ccl_pkg::cfg_t   cfg,
  input  ccl_pkg::in_t    item,
  output ccl_pkg::state_t nxt
);
  import ccl_pkg::*;

  logic [7:0]  both_bits;
  logic [7:0]  line_bits;
  logic        inserted;
  logic        seat_match;
  logic [1:0]  err_in;
  logic [31:0] wait_base;
  logic [31:0] lock_base;
  logic [31:0] base;
  logic [15:0] limit;
  logic [31:0] elapsed;
  logic        expired;
  logic [1:0]  phase_a;

  assign both_bits  = cfg.seat_one_bits | cfg.seat_two_bits;
  assign line_bits  = {3'b000, cfg.line_detect_bits};
  assign inserted   = ((item.detect_mask & line_bits) != 8'd0) &&
                      ((item.detect_mask & ~line_bits) != 8'd0);
  assign seat_match = (item.power_mask == cfg.seat_one_bits) ||
                      (item.power_mask == cfg.seat_two_bits);
  assign err_in     = item.clear_error ? ERR_OK : cur.stored_error;

  // wait timer starts on this pass when not yet running
  assign wait_base = cur.wait_running ? cur.wait_start : item.now_ms;

  // lock phase and stamp after a possible start of engage or release
  always_comb begin
    phase_a   = cur.lock_phase;
    lock_base = cur.lock_stamp;
    if (cur.current_mode == MODE_END) begin
      if (item.detect_mask == line_bits && cur.lock_phase == PHASE_LOCKED) begin
        phase_a   = PHASE_RELEASING;
        lock_base = item.now_ms;
      end
    end else if (cur.lock_phase == PHASE_OPEN) begin
      phase_a   = PHASE_ENGAGING;
      lock_base = item.now_ms;
    end
  end

  // one shared elapsed-time compare
  always_comb begin
    case (cur.current_mode)
      MODE_IDLE: begin
        base  = wait_base;
        limit = cfg.power_timeout_ms;
      end
      MODE_END: begin
        base  = lock_base;
        limit = cfg.lock_open_ms;
      end
      default: begin
        base  = lock_base;
        limit = cfg.lock_close_ms;
      end
    endcase
  end

  assign elapsed = item.now_ms - base;
  assign expired = elapsed >= {16'd0, limit};

  always_comb begin
    nxt              = cur;
    nxt.stored_error = err_in;
    case (cur.current_mode)
      MODE_IDLE: begin
        if (item.detect_mask != 8'd0) begin
          if (item.detect_mask > DETECT_LIMIT) begin
            nxt.current_mode = MODE_FAULT;
            nxt.stored_error = ERR_OVERFLOW;
          end else if (inserted) begin
            nxt.wait_running = 1'b1;
            nxt.wait_start   = wait_base;
            if (expired && err_in != ERR_TIMEOUT) begin
              nxt.current_mode = MODE_FAULT;
              nxt.stored_error = ERR_TIMEOUT;
              nxt.wait_running = 1'b0;
            end else if (seat_match) begin
              nxt.current_mode = MODE_ONE;
            end else if (item.power_mask == both_bits) begin
              nxt.current_mode = MODE_TWO;
            end
          end else begin
            nxt.wait_running = 1'b0;
          end
        end
      end
      MODE_ONE, MODE_TWO: begin
        nxt.lock_phase = phase_a;
        nxt.lock_stamp = lock_base;
        if (cur.lock_phase == PHASE_OPEN) begin
          nxt.drive_level = DRIVE_ENGAGE;
        end
        if (phase_a == PHASE_ENGAGING && expired) begin
          nxt.drive_level = DRIVE_STOP;
          nxt.lock_phase  = PHASE_LOCKED;
        end
        if (cur.current_mode == MODE_ONE) begin
          if (item.power_mask == both_bits) begin
            nxt.current_mode = MODE_TWO;
          end else if (item.power_mask == 8'd0 && nxt.lock_phase == PHASE_LOCKED) begin
            nxt.current_mode = MODE_END;
          end
        end else begin
          if (seat_match) begin
            nxt.current_mode = MODE_ONE;
          end else if (item.power_mask == 8'd0 && nxt.lock_phase == PHASE_LOCKED) begin
            nxt.current_mode = MODE_END;
          end
        end
      end
      MODE_END: begin
        if (item.power_mask == 8'd0) begin
          nxt.lock_phase = phase_a;
          nxt.lock_stamp = lock_base;
          if (phase_a == PHASE_RELEASING && cur.lock_phase == PHASE_LOCKED) begin
            nxt.drive_level = DRIVE_RELEASE;
          end
          if (phase_a == PHASE_RELEASING && expired) begin
            nxt.drive_level = DRIVE_STOP;
            nxt.lock_phase  = PHASE_OPEN;
          end
          if (item.detect_mask == 8'd0 && nxt.lock_phase == PHASE_OPEN) begin
            nxt.current_mode = MODE_IDLE;
          end
        end
      end
      default: begin
        nxt.current_mode = MODE_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/charge_connector_lock_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charge_connector_lock_fsm: charge connector lock controller
// five-mode charger controller with cable lock timing and error reporting
// ----------------------------------------------------------------------------
// Each input transaction is one control pass of the charger controller: the
// pass is evaluated combinationally by ccl_step and the new controller
// state and the result transaction are registered at the accepting edge.
// One transaction is taken per clock; the result register on the output side
// lets a new input be taken in the same cycle the previous result is taken,
// so in_ready drops only while a result sits unread and out_ready is low.
// out_valid rises in the cycle after an input is accepted. The timing limits
// (engage, release, power-message wait) are all checked by one 32-bit
// subtract-and-compare against the millisecond stamp on the input. The six
// registers sit on an APB-style port at byte addresses 0x00..0x14 and should
// be written while the block is idle.
// ----------------------------------------------------------------------------
module charge_connector_lock_fsm (
  input  logic           clk,
  input  logic           rst,
  // input channel
  input  logic           in_valid,
  output logic           in_ready,
  input  ccl_pkg::in_t   in_data,
  // result channel
  output logic           out_valid,
  input  logic           out_ready,
  output ccl_pkg::out_t  out_data,
  // configuration port
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import ccl_pkg::*;

  cfg_t   cfg;        // configuration registers
  state_t st;         // controller state
  state_t st_next;    // state after this pass
  logic   in_fire;
  logic   cfg_write;
  logic [2:0] reg_index;

  // register index from the word address
  assign reg_index = paddr[4:2];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // configuration writes, addresses past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_detect_bits <= LINE_DETECT_RST;
      cfg.seat_one_bits    <= SEAT_ONE_RST;
      cfg.seat_two_bits    <= SEAT_TWO_RST;
      cfg.lock_close_ms    <= LOCK_CLOSE_RST;
      cfg.lock_open_ms     <= LOCK_OPEN_RST;
      cfg.power_timeout_ms <= POWER_TIMEOUT_RST;
    end else if (cfg_write) begin
      case (reg_index)
        REG_LINE_DETECT:   cfg.line_detect_bits <= pwdata[4:0];
        REG_SEAT_ONE:      cfg.seat_one_bits    <= pwdata[7:0];
        REG_SEAT_TWO:      cfg.seat_two_bits    <= pwdata[7:0];
        REG_LOCK_CLOSE:    cfg.lock_close_ms    <= pwdata[15:0];
        REG_LOCK_OPEN:     cfg.lock_open_ms     <= pwdata[15:0];
        REG_POWER_TIMEOUT: cfg.power_timeout_ms <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_index)
      REG_LINE_DETECT:   prdata = {27'd0, cfg.line_detect_bits};
      REG_SEAT_ONE:      prdata = {24'd0, cfg.seat_one_bits};
      REG_SEAT_TWO:      prdata = {24'd0, cfg.seat_two_bits};
      REG_LOCK_CLOSE:    prdata = {16'd0, cfg.lock_close_ms};
      REG_LOCK_OPEN:     prdata = {16'd0, cfg.lock_open_ms};
      REG_POWER_TIMEOUT: prdata = {16'd0, cfg.power_timeout_ms};
      default:           prdata = 32'd0;
    endcase
  end

  // take a new transaction whenever the result register is free or draining
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // one control pass
  ccl_step u_step (
    .cur  (st),
    .cfg  (cfg),
    .item (in_data),
    .nxt  (st_next)
  );

  // controller state advances once per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      st.current_mode <= MODE_IDLE;
      st.stored_error <= ERR_OK;
      st.lock_phase   <= PHASE_OPEN;
      st.lock_stamp   <= 32'd0;
      st.wait_running <= 1'b0;
      st.wait_start   <= 32'd0;
      st.drive_level  <= DRIVE_STOP;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data.mode       <= st_next.current_mode;
      out_data.error_code <= st_next.stored_error;
      out_data.lock_drive <= st_next.drive_level;
      out_data.error_led  <= (st_next.stored_error != ERR_OK);
    end
  end

  // fault mode lasts a single pass
  a_fault_one_pass: assert property (@(posedge clk) disable iff (rst)
    (in_fire && st.current_mode == MODE_FAULT) |=> (st.current_mode == MODE_IDLE))
    else $error("fault mode held past one pass");

  // an engaging drive only while the lock is engaging
  a_engage_phase: assert property (@(posedge clk) disable iff (rst)
    (st.drive_level == DRIVE_ENGAGE) |-> (st.lock_phase == PHASE_ENGAGING))
    else $error("engage drive outside engaging phase");

  // a releasing drive only while the lock is releasing
  a_release_phase: assert property (@(posedge clk) disable iff (rst)
    (st.drive_level == DRIVE_RELEASE) |-> (st.lock_phase == PHASE_RELEASING))
    else $error("release drive outside releasing phase");

  // a fault result always carries an error code
  a_fault_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.mode == MODE_FAULT) |-> (out_data.error_code != ERR_OK))
    else $error("fault result without error code");

endmodule
